/* hw/rtl/tsd_pkg.sv */
// Package for the timestamp difference core: stamp type, direction codes, calendar helpers.
`timescale 1ns / 1ps
`default_nettype none

package tsd_pkg;

  // Radix of each fixed-radix span digit
  localparam int unsigned MsRadix   = 1000;
  localparam int unsigned SecRadix  = 60;
  localparam int unsigned MinRadix  = 60;
  localparam int unsigned HourRadix = 24;
  localparam int unsigned MonRadix  = 12;

  localparam int unsigned InWidth  = 104;
  localparam int unsigned OutWidth = 56;

  // Fields ordered from most to least significant, so a packed compare
  // of two stamps is the field-by-field calendar compare.
  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [9:0]  milli;
  } stamp_t;

  typedef enum logic [1:0] {
    DIR_EQUAL  = 2'd0,
    DIR_FUTURE = 2'd1,
    DIR_PAST   = 2'd2
  } dir_e;

  typedef struct packed {
    logic [9:0]  millis;
    logic [5:0]  seconds;
    logic [5:0]  minutes;
    logic [4:0]  hours;
    logic [4:0]  days;
    logic [3:0]  months;
    logic [15:0] years;
  } span_t;

  // Length of a month; zero for a month code outside 1..12
  function automatic logic [4:0] days_in_month(input logic [3:0] month,
                                               input logic [15:0] year);
    logic [4:0] len;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:    len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic stamp_t unpack(input logic [24:0] date, input logic [26:0] clock);
    stamp_t s;
    s.year   = date[24:9];
    s.month  = date[8:5];
    s.day    = date[4:0];
    s.hour   = clock[26:22];
    s.minute = clock[21:16];
    s.second = clock[15:10];
    s.milli  = clock[9:0];
    return s;
  endfunction

  function automatic logic stamp_valid(input stamp_t s);
    logic [4:0] len;
    len = days_in_month(s.month, s.year);
    return (len != 5'd0) && (s.day != 5'd0) && (s.day <= len) &&
           (s.hour < 5'(HourRadix)) && (s.minute < 6'(MinRadix)) &&
           (s.second < 6'(SecRadix)) && (s.milli < 10'(MsRadix));
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/timestamp_difference_core.sv */
// Calendar timestamp difference core: three-stage compare and borrow-chain pipeline.
//
// Usage: one transaction on the slave stream carries a start and a target
// timestamp; one transaction on the master stream returns the direction,
// an invalid flag and the span (later minus earlier) in mixed radix.
// Each pair passes through the stage 1, stage 2 and stage 3 registers;
// m_axis_tvalid is the stage 3 valid bit. One timestamp pair is accepted
// every clock unless a stall on m_axis_tready backs up the pipeline.
// Stage 1 unpacks, checks ranges and compares; stage 2 orders the stamps
// and subtracts the millisecond through hour digits; stage 3 subtracts
// day, month and year and forms the output register. Each stage advances
// when empty or when the next stage advances; a stall on m_axis_tready
// closes up empty stages, holds full ones, backs up to s_axis_tready, and loses or duplicates nothing.
// Reset clears all valid bits; payload registers are not reset.
// Out-of-range fields set invalid_input and zero the span; the direction
// is still reported from the raw fields.
`timescale 1ns / 1ps
`default_nettype none

module timestamp_difference_core
  import tsd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // from_date[24:0], from_clock[51:25], to_date[76:52], to_clock[103:77]
  input  wire logic [InWidth-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // direction[1:0], invalid_input[2], span_years[18:3], span_months[22:19],
  // span_days[27:23], span_hours[32:28], span_minutes[38:33],
  // span_seconds[44:39], span_millis[54:45], zero pad[55]
  output logic [OutWidth-1:0]      m_axis_tdata
);

  // Stage enables
  logic en1, en2, en3;
  logic v1_q, v2_q, v3_q;

  assign en3 = !v3_q || m_axis_tready;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign s_axis_tready = en1;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // Stage 1: unpack, range check, compare
  stamp_t from_d, to_d, from_q, to_q;
  dir_e   dir1_d, dir1_q;
  logic   bad1_d, bad1_q;

  always_comb begin
    from_d = unpack(s_axis_tdata[24:0], s_axis_tdata[51:25]);
    to_d   = unpack(s_axis_tdata[76:52], s_axis_tdata[103:77]);
    bad1_d = !stamp_valid(from_d) || !stamp_valid(to_d);
    if (to_d > from_d) begin
      dir1_d = DIR_FUTURE;
    end else if (to_d < from_d) begin
      dir1_d = DIR_PAST;
    end else begin
      dir1_d = DIR_EQUAL;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      from_q <= from_d;
      to_q   <= to_d;
      dir1_q <= dir1_d;
      bad1_q <= bad1_d;
    end
  end

  // Stage 2: order the stamps, subtract the time-of-day digits
  stamp_t      hi, lo;
  logic [10:0] ms_diff;
  logic [6:0]  sec_diff, min_diff;
  logic [5:0]  hr_diff;
  logic        b_ms, b_sec, b_min;
  logic [9:0]  ms2_d, ms2_q;
  logic [5:0]  sec2_d, sec2_q, min2_d, min2_q;
  logic [4:0]  hr2_d, hr2_q;
  logic        bhr2_d, bhr2_q;
  logic [4:0]  mlen2_d, mlen2_q;
  logic [15:0] hi_year_q, lo_year_q;
  logic [3:0]  hi_mon_q, lo_mon_q;
  logic [4:0]  hi_day_q, lo_day_q;
  dir_e        dir2_q;
  logic        bad2_q;

  always_comb begin
    hi = (dir1_q == DIR_FUTURE) ? to_q : from_q;
    lo = (dir1_q == DIR_FUTURE) ? from_q : to_q;

    ms_diff = {1'b0, hi.milli} - {1'b0, lo.milli};
    b_ms    = ms_diff[10];
    ms2_d   = b_ms ? ms_diff[9:0] + 10'(MsRadix) : ms_diff[9:0];

    sec_diff = {1'b0, hi.second} - {1'b0, lo.second} - 7'(b_ms);
    b_sec    = sec_diff[6];
    sec2_d   = b_sec ? sec_diff[5:0] + 6'(SecRadix) : sec_diff[5:0];

    min_diff = {1'b0, hi.minute} - {1'b0, lo.minute} - 7'(b_sec);
    b_min    = min_diff[6];
    min2_d   = b_min ? min_diff[5:0] + 6'(MinRadix) : min_diff[5:0];

    hr_diff = {1'b0, hi.hour} - {1'b0, lo.hour} - 6'(b_min);
    bhr2_d  = hr_diff[5];
    hr2_d   = bhr2_d ? hr_diff[4:0] + 5'(HourRadix) : hr_diff[4:0];

    mlen2_d = days_in_month(lo.month, lo.year);
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      ms2_q     <= ms2_d;
      sec2_q    <= sec2_d;
      min2_q    <= min2_d;
      hr2_q     <= hr2_d;
      bhr2_q    <= bhr2_d;
      mlen2_q   <= mlen2_d;
      hi_year_q <= hi.year;
      lo_year_q <= lo.year;
      hi_mon_q  <= hi.month;
      lo_mon_q  <= lo.month;
      hi_day_q  <= hi.day;
      lo_day_q  <= lo.day;
      dir2_q    <= dir1_q;
      bad2_q    <= bad1_q;
    end
  end

  // Stage 3: subtract the calendar digits, zero the span when not meaningful
  logic [5:0]  day_diff;
  logic [4:0]  mon_diff;
  logic        b_day, b_mon;
  span_t       span_d, span_q;
  dir_e        dir3_q;
  logic        bad3_q;

  always_comb begin
    day_diff = {1'b0, hi_day_q} - {1'b0, lo_day_q} - 6'(bhr2_q);
    b_day    = day_diff[5];
    mon_diff = {1'b0, hi_mon_q} - {1'b0, lo_mon_q} - 5'(b_day);
    b_mon    = mon_diff[4];

    span_d.millis  = ms2_q;
    span_d.seconds = sec2_q;
    span_d.minutes = min2_q;
    span_d.hours   = hr2_q;
    span_d.days    = b_day ? day_diff[4:0] + mlen2_q : day_diff[4:0];
    span_d.months  = b_mon ? mon_diff[3:0] + 4'(MonRadix) : mon_diff[3:0];
    span_d.years   = hi_year_q - lo_year_q - 16'(b_mon);
    if (bad2_q || dir2_q == DIR_EQUAL) begin
      span_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      span_q <= span_d;
      dir3_q <= dir2_q;
      bad3_q <= bad2_q;
    end
  end

  // Pack the result transaction
  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = {1'b0, span_q.millis, span_q.seconds, span_q.minutes,
                          span_q.hours, span_q.days, span_q.months, span_q.years,
                          bad3_q, dir3_q};

  // Checks
  a_invalid_zero_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && bad3_q) |-> (span_q == '0))
    else $error("invalid input produced a nonzero span");

  a_equal_zero_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && dir3_q == DIR_EQUAL) |-> (span_q == '0))
    else $error("equal timestamps produced a nonzero span");

  a_stage1_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !en2) |=> (v1_q && $stable(from_q) && $stable(to_q)))
    else $error("stage 1 item lost under stall");

  a_stage2_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !en3) |=> (v2_q && $stable(ms2_q) && $stable(hi_year_q)))
    else $error("stage 2 item lost under stall");

endmodule

`default_nettype wire
